[design/rita_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rita_pkg: shared definitions for the radix integer to ASCII converter
// Radix register limits, digit and character widths, digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rita_pkg;

	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd87;  // 'a' minus ten
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

	// Map one digit to '0'..'9' or 'a'..'f'.
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < DIGIT_TEN) begin
			to_ascii = CHAR_ZERO + ext;
		end else begin
			to_ascii = CHAR_LETTER + ext;
		end
	endfunction

endpackage
`default_nettype wire

[design/rita_value_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rita_value_if: input channel carrying one integer value per beat
// Valid/ready handshake; a beat moves when both are high at a rising edge.
// ----------------------------------------------------------------------------
interface rita_value_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[design/rita_digit_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rita_digit_if: output channel carrying one ASCII digit per beat
// Valid/ready handshake; last_digit marks the final digit of a value.
// ----------------------------------------------------------------------------
interface rita_digit_if;
	logic                        valid;
	logic                        ready;
	logic [rita_pkg::CHAR_W-1:0] digit_char;
	logic                        last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

[design/rita_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rita_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rita_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[design/radix_integer_to_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: unsigned integer to ASCII digits in radix 2..16
// Bit-serial division by the radix; digits emitted most significant first.
// ----------------------------------------------------------------------------
// Each accepted value is divided repeatedly by the radix with one bit-serial
// restoring divider, one quotient bit per cycle; division stops when the
// quotient is zero (zero gives the single digit '0'). Remainders are stored
// in a small digit RAM, then read back in reverse and sent one beat per
// digit: each digit is read from the RAM, loaded into the output register
// and held until the sink takes it. The block takes no new value until the
// last digit is delivered.
// Only the least significant MAX_DIGITS digits are kept; the last one sent
// carries last_digit. The radix register resets to ten and saturates writes
// to the range two through sixteen; write it only while the block is idle.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [rita_pkg::RADIX_W-1:0] cfg_wr_data,
	rita_value_if.sink                        value_ch,
	rita_digit_if.source                      digit_ch
);

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int ADDR_W    = $clog2(MAX_DIGITS);
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_BITS - 1);
	localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(MAX_DIGITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DIGIT,
		ST_READ,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [rita_pkg::RADIX_W-1:0] radix_q;
	logic [rita_pkg::RADIX_W-1:0] base_q;
	logic [VALUE_BITS-1:0]        quot_q;   // dividend shifts out, quotient shifts in
	logic [rita_pkg::DIGIT_W-1:0] rem_q;
	logic [BIT_CNT_W-1:0]         bit_cnt_q;
	logic [CNT_W-1:0]             count_q;
	logic [ADDR_W-1:0]            rd_addr_q;
	logic                         out_valid_q;
	logic [rita_pkg::CHAR_W-1:0]  out_char_q;
	logic                         out_last_q;

	// Shared divider step: bring down the next dividend bit, trial subtract.
	logic [rita_pkg::RADIX_W-1:0] trial;
	logic                         trial_ge;
	logic [rita_pkg::RADIX_W-1:0] trial_diff;
	logic [rita_pkg::DIGIT_W-1:0] rem_next;

	assign trial      = {rem_q, quot_q[VALUE_BITS-1]};
	assign trial_ge   = (trial >= base_q);
	assign trial_diff = trial - base_q;
	assign rem_next   = trial_ge ? trial_diff[rita_pkg::DIGIT_W-1:0]
	                             : trial[rita_pkg::DIGIT_W-1:0];

	// Digit store bookkeeping: drop digits beyond MAX_DIGITS.
	logic              buf_full;
	logic [CNT_W-1:0]  count_new;
	logic [CNT_W-1:0]  count_last;
	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [rita_pkg::DIGIT_W-1:0] ram_rd_data;

	assign buf_full   = (count_q == FULL_CNT);
	assign count_new  = buf_full ? count_q : count_q + 1'b1;
	assign count_last = count_new - 1'b1;
	assign ram_wr_en  = (state_q == ST_DIGIT) && !buf_full;
	assign ram_rd_en  = (state_q == ST_READ);

	rita_ram #(
		.WIDTH (rita_pkg::DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digit_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (rem_q),
		.rd_en   (ram_rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (ram_rd_data)
	);

	// Radix register: saturate writes into two through sixteen.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rita_pkg::RADIX_RESET;
		end else if (cfg_wr_en) begin
			priority if (cfg_wr_data < rita_pkg::RADIX_MIN) begin
				radix_q <= rita_pkg::RADIX_MIN;
			end else if (cfg_wr_data > rita_pkg::RADIX_MAX) begin
				radix_q <= rita_pkg::RADIX_MAX;
			end else begin
				radix_q <= cfg_wr_data;
			end
		end
	end

	// Sequencer: divide, store each digit, then replay digits in reverse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= rita_pkg::RADIX_RESET;
			quot_q      <= '0;
			rem_q       <= '0;
			bit_cnt_q   <= '0;
			count_q     <= '0;
			rd_addr_q   <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (value_ch.valid) begin
						quot_q    <= value_ch.value;
						base_q    <= radix_q;
						rem_q     <= '0;
						bit_cnt_q <= '0;
						count_q   <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					// Advance one quotient bit per cycle.
					rem_q     <= rem_next;
					quot_q    <= {quot_q[VALUE_BITS-2:0], trial_ge};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == LAST_BIT) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					count_q <= count_new;
					if (quot_q != '0) begin
						rem_q     <= '0;
						bit_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						rd_addr_q <= count_last[ADDR_W-1:0];
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_char_q  <= rita_pkg::to_ascii(ram_rd_data);
					out_last_q  <= (rd_addr_q == '0);
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					// Hold the beat until the sink takes it.
					if (digit_ch.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							rd_addr_q <= rd_addr_q - 1'b1;
							state_q   <= ST_READ;
						end
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign value_ch.ready      = (state_q == ST_IDLE);
	assign digit_ch.valid      = out_valid_q;
	assign digit_ch.digit_char = out_char_q;
	assign digit_ch.last_digit = out_last_q;

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for radix_integer_to_ascii
// Drives integer values over the value channel and checks every ASCII digit
// beat against a local prediction of repeated division by the radix, through
// saturating radix writes and mixed sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 32;
	localparam int RADIX_W    = rita_pkg::RADIX_W;
	localparam int CHAR_W     = rita_pkg::CHAR_W;

	// One digit beat as it should leave the block.
	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_beat_t;

	// Predicts the digit string of each accepted value and holds the beats
	// still owed by the block, oldest first.
	class digit_tracker_t;
		digit_beat_t       owed_digits[$];
		logic [RADIX_W-1:0] base;
		int                errors;

		function new();
			base   = rita_pkg::RADIX_RESET;
			errors = 0;
		endfunction

		// Saturate a raw register write the way the block stores it.
		function void set_radix(logic [RADIX_W-1:0] raw);
			if (raw < rita_pkg::RADIX_MIN) begin
				base = rita_pkg::RADIX_MIN;
			end else if (raw > rita_pkg::RADIX_MAX) begin
				base = rita_pkg::RADIX_MAX;
			end else begin
				base = raw;
			end
		endfunction

		// Spell the value out, least significant first, then queue the
		// kept digits most significant first.
		function void note_value(logic [VALUE_BITS-1:0] value);
			string             glyphs;
			logic [CHAR_W-1:0] spelled[$];
			logic [VALUE_BITS-1:0] quot;
			logic [VALUE_BITS-1:0] rem;
			digit_beat_t       beat;
			glyphs = "0123456789abcdef";
			quot   = value;
			do begin
				rem  = quot % VALUE_BITS'(base);
				quot = quot / VALUE_BITS'(base);
				if (spelled.size() < MAX_DIGITS) begin
					spelled.push_back(CHAR_W'(glyphs[rem[3:0]]));
				end
			end while (quot != 0);
			for (int k = spelled.size() - 1; k >= 0; k--) begin
				beat.digit_char = spelled[k];
				beat.last_digit = (k == 0);
				owed_digits.push_back(beat);
			end
		endfunction

		function void check_digit(logic [CHAR_W-1:0] digit_char, logic last_digit);
			digit_beat_t want;
			if (owed_digits.size() == 0) begin
				$error("unexpected digit beat: digit_char %0d last_digit %0b",
					digit_char, last_digit);
				errors++;
				return;
			end
			want = owed_digits.pop_front();
			if (digit_char !== want.digit_char) begin
				$error("digit_char expected %0d actual %0d", want.digit_char, digit_char);
				errors++;
			end
			if (last_digit !== want.last_digit) begin
				$error("last_digit expected %0b actual %0b", want.last_digit, last_digit);
				errors++;
			end
		endfunction

		function int pending();
			return owed_digits.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [RADIX_W-1:0] cfg_wr_data;

	rita_value_if #(.VALUE_BITS(VALUE_BITS)) value_ch ();
	rita_digit_if digit_ch ();

	radix_integer_to_ascii #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.value_ch   (value_ch),
		.digit_ch   (digit_ch)
	);

	digit_tracker_t tracker = new();

	// Stall pattern: sender pauses before 22 / receiver idles 60 in each hundred
	// values / cycles in the first third of the values, swapped in the second, none in the last.
	int values_sent   = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 60;

	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	// Run time guard. Slowest legal run: about 460 values of 32 digits, each
	// digit held by a long receiver stall, plus the sender gaps. On timeout the
	// bench reports TB_ERROR.
	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Update the stall pattern from the number of values accepted so far.
	always @(posedge clk) begin
		if (values_sent < 153) begin
			send_idle_pct <= 22;
			recv_idle_pct <= 60;
		end else if (values_sent < 306) begin
			send_idle_pct <= 60;
			recv_idle_pct <= 22;
		end else begin
			send_idle_pct <= 0;
			recv_idle_pct <= 0;
		end
	end

	// Digit sink: check each beat that moves, then pick the next ready.
	initial begin
		digit_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && digit_ch.valid && digit_ch.ready) begin
				tracker.check_digit(digit_ch.digit_char, digit_ch.last_digit);
			end
			digit_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one value and hold it until accepted. Valid stays high on return
	// so a back-to-back value keeps it up without a drop in the same step.
	task automatic send_value(input logic [VALUE_BITS-1:0] value);
		int gap;
		gap = 0;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
		end
		if (gap > 0) begin
			value_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.value <= value;
		do begin
			@(posedge clk);
		end while (!value_ch.ready);
		tracker.note_value(value);
		values_sent++;
	endtask

	// Drop valid and hold off until every owed digit has arrived.
	task automatic drain_digits();
		value_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Write the radix while the block is idle; the tracker follows the edge.
	task automatic write_radix(input logic [RADIX_W-1:0] raw);
		drain_digits();
		repeat (40) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= raw;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_radix(raw);
	endtask

	// Pick one random value: full-width two times in five, plus short values, radix
	// powers and their neighbors, and the corners.
	function automatic logic [VALUE_BITS-1:0] pick_value();
		int unsigned pick;
		logic [63:0] power;
		int          steps;
		pick = $urandom_range(99);
		if (pick < 40) begin
			return $urandom;
		end else if (pick < 60) begin
			return $urandom >> $urandom_range(31);
		end else if (pick < 75) begin
			power = 1;
			steps = $urandom_range(1, 32);
			for (int k = 0; k < steps; k++) begin
				power = power * tracker.base;
			end
			power = power + 64'($urandom_range(2)) - 64'd1;
			return power[VALUE_BITS-1:0];
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: return '1;
				1: return '0;
				2: return 1;
				default: return $urandom_range(0, 2 * tracker.base);
			endcase
		end
		return $urandom_range(0, 1000);
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			// Pause once mid-run until the block has emptied out.
			if (values_sent == 230) begin
				drain_digits();
			end
			send_value(pick_value());
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		value_ch.valid <= 1'b0;
		value_ch.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset radix ten: zero, single digits, the carry into two digits,
		// full scale, the top bit alone and the carry into ten digits.
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd999_999_999);
		send_value(32'd1_000_000_000);
		send_random(50);

		// Write below range: saturates to two. Full scale gives the widest
		// string, 32 digits.
		write_radix(5'd0);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd1);
		send_value(32'd0);
		send_random(50);

		// Write above range: saturates to sixteen. Cover every letter.
		write_radix(5'd31);
		send_value(32'hABCD_EF01);
		send_value(32'hFFFF_FFFF);
		send_value(32'd15);
		send_value(32'd16);
		send_random(50);

		// Just outside the range on both sides, then its exact ends.
		write_radix(5'd1);
		send_random(45);
		write_radix(5'd17);
		send_random(45);
		write_radix(rita_pkg::RADIX_MAX);
		send_random(40);
		write_radix(rita_pkg::RADIX_MIN);
		send_random(40);

		// Interior radices, then back to ten.
		write_radix(5'($urandom_range(3, 15)));
		send_random(50);
		write_radix(5'($urandom_range(3, 15)));
		send_random(50);
		write_radix(rita_pkg::RADIX_RESET);
		send_random(30);

		// Drain, then leave room for any stray beat before the verdict.
		drain_digits();
		repeat (100) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

[radix_integer_to_ascii.f]
design/rita_pkg.sv
design/rita_value_if.sv
design/rita_digit_if.sv
design/rita_ram.sv
design/radix_integer_to_ascii.sv
dv/tb.sv
